// ===== rtl/core/irpdt_pkg.sv =====
// Package for the IR pulse-distance transmitter: sizes, phase codes,
// register map, reset values and the structs shared by the core files.
// No dependencies.
`timescale 1ns / 1ps

package irpdt_pkg;

    localparam int MAX_FRAME_BITS   = 64;
    localparam int TICK_COUNT_WIDTH = 16;

    localparam int FRAME_BITS_W = 64;   // input field width
    localparam int SEG_LEN_W    = 16;   // segment length register width
    localparam int BIT_COUNT_W  = 7;
    localparam int REPEATS_W    = 4;
    localparam int BITS_LEFT_W  = $clog2(MAX_FRAME_BITS + 1);
    localparam int LEN_CMP_W    = (TICK_COUNT_WIDTH > SEG_LEN_W) ? TICK_COUNT_WIDTH : SEG_LEN_W;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STOP_SPACE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BIT_COUNT    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_REPEATS      = 3'd7;

    localparam logic [SEG_LEN_W-1:0]   RST_LEADER_MARK  = 16'd338;
    localparam logic [SEG_LEN_W-1:0]   RST_LEADER_SPACE = 16'd338;
    localparam logic [SEG_LEN_W-1:0]   RST_BIT_MARK     = 16'd41;
    localparam logic [SEG_LEN_W-1:0]   RST_ONE_SPACE    = 16'd124;
    localparam logic [SEG_LEN_W-1:0]   RST_ZERO_SPACE   = 16'd41;
    localparam logic [SEG_LEN_W-1:0]   RST_STOP_SPACE   = 16'd401;
    localparam logic [BIT_COUNT_W-1:0] RST_BIT_COUNT    = 7'd48;
    localparam logic [REPEATS_W-1:0]   RST_REPEATS      = 4'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LMARK  = 3'd1,
        PH_LSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4,
        PH_SMARK  = 3'd5,
        PH_SSPACE = 3'd6
    } t_phase;

    typedef struct packed {
        logic [SEG_LEN_W-1:0]   leader_mark;
        logic [SEG_LEN_W-1:0]   leader_space;
        logic [SEG_LEN_W-1:0]   bit_mark;
        logic [SEG_LEN_W-1:0]   one_space;
        logic [SEG_LEN_W-1:0]   zero_space;
        logic [SEG_LEN_W-1:0]   stop_space;
        logic [BIT_COUNT_W-1:0] frame_bit_count;
        logic [REPEATS_W-1:0]   frame_repeats;
    } t_cfg;

    typedef struct packed {
        logic ir_out;
        logic busy_res;
        logic start_refused;
        logic sequence_done;
    } t_result;

endpackage

// ===== rtl/core/irpdt_engine.sv =====
// Frame sequencer: phase, tick counter, shift register and counts.
// Updates state on each accepted transaction and returns its result combinationally.
// Depends on irpdt_pkg.
`timescale 1ns / 1ps

module irpdt_engine
    import irpdt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic                    i_op,
    input  logic [FRAME_BITS_W-1:0] i_frame_bits,
    input  t_cfg                    i_cfg,
    output t_result                 o_res
);

    localparam logic [TICK_COUNT_WIDTH-1:0] CNT_MAX = {TICK_COUNT_WIDTH{1'b1}};
    localparam logic [LEN_CMP_W-1:0] CNT_MAX_EXT = LEN_CMP_W'(CNT_MAX);

    t_phase                      r_phase, n_phase;
    logic [TICK_COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [MAX_FRAME_BITS-1:0]   r_shift, n_shift;
    logic [MAX_FRAME_BITS-1:0]   r_frame, n_frame;
    logic [BITS_LEFT_W-1:0]      r_bits_left, n_bits_left;
    logic [BITS_LEFT_W-1:0]      r_frame_len, n_frame_len;
    logic [REPEATS_W-1:0]        r_repeats, n_repeats;
    logic                        r_pin, n_pin;

    t_phase                      phase_cur;
    logic                        busy;
    logic [SEG_LEN_W-1:0]        len_raw;
    logic [LEN_CMP_W-1:0]        len_eff;
    logic [TICK_COUNT_WIDTH-1:0] tick_inc;
    logic                        seg_end;
    logic [BITS_LEFT_W-1:0]      start_len;
    logic [BITS_LEFT_W-1:0]      start_sh;
    logic [MAX_FRAME_BITS-1:0]   start_data;
    logic [BITS_LEFT_W-1:0]      bits_dec;
    logic [REPEATS_W-1:0]        rep_dec;
    logic                        refused;
    logic                        done;

    // segment length, end-of-segment detect, start frame setup and count decrements
    always_comb begin
        case (r_phase)
            PH_IDLE, PH_LMARK, PH_LSPACE, PH_BMARK,
            PH_BSPACE, PH_SMARK, PH_SSPACE: phase_cur = r_phase;
            default:                        phase_cur = PH_IDLE;
        endcase
        busy = (phase_cur != PH_IDLE);

        case (phase_cur)
            PH_LMARK:  len_raw = i_cfg.leader_mark;
            PH_LSPACE: len_raw = i_cfg.leader_space;
            PH_BMARK:  len_raw = i_cfg.bit_mark;
            PH_BSPACE: len_raw = r_shift[MAX_FRAME_BITS-1] ? i_cfg.one_space
                                                           : i_cfg.zero_space;
            PH_SMARK:  len_raw = i_cfg.bit_mark;
            default:   len_raw = i_cfg.stop_space;
        endcase
        // zero acts as one, clip to counter range
        len_eff = (len_raw == '0) ? LEN_CMP_W'(1) : LEN_CMP_W'(len_raw);
        if (len_eff > CNT_MAX_EXT) begin
            len_eff = CNT_MAX_EXT;
        end

        tick_inc = (r_tick != CNT_MAX) ? r_tick + 1'b1 : r_tick;
        seg_end  = (LEN_CMP_W'(tick_inc) >= len_eff);

        if (i_cfg.frame_bit_count > BIT_COUNT_W'(MAX_FRAME_BITS)) begin
            start_len = BITS_LEFT_W'(MAX_FRAME_BITS);
        end else begin
            start_len = BITS_LEFT_W'(i_cfg.frame_bit_count);
        end
        start_sh   = BITS_LEFT_W'(MAX_FRAME_BITS) - start_len;
        start_data = (start_len != '0) ? (i_frame_bits[MAX_FRAME_BITS-1:0] << start_sh) : '0;

        bits_dec = (r_bits_left != '0) ? r_bits_left - 1'b1 : r_bits_left;
        rep_dec  = (r_repeats != '0) ? r_repeats - 1'b1 : r_repeats;
    end

    // next state
    always_comb begin
        n_phase     = phase_cur;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_frame     = r_frame;
        n_bits_left = r_bits_left;
        n_frame_len = r_frame_len;
        n_repeats   = r_repeats;
        n_pin       = r_pin;
        refused     = 1'b0;
        done        = 1'b0;

        if (i_op == OP_START) begin
            if (busy) begin
                refused = 1'b1;
            end else begin
                n_frame     = start_data;
                n_frame_len = start_len;
                n_repeats   = (i_cfg.frame_repeats == '0) ? REPEATS_W'(1) : i_cfg.frame_repeats;
                n_shift     = start_data;
                n_bits_left = start_len;
                n_phase     = PH_LMARK;
                n_tick      = '0;
            end
        end else if (!busy) begin
            n_pin = 1'b1;
        end else begin
            if (phase_cur == PH_LMARK || phase_cur == PH_BMARK || phase_cur == PH_SMARK) begin
                n_pin = ~r_pin;
            end else begin
                n_pin = 1'b1;
            end
            n_tick = tick_inc;
            if (seg_end) begin
                n_tick = '0;
                case (phase_cur)
                    PH_LMARK:  n_phase = PH_LSPACE;
                    PH_LSPACE: n_phase = (r_bits_left != '0) ? PH_BMARK : PH_SMARK;
                    PH_BMARK:  n_phase = PH_BSPACE;
                    PH_BSPACE: begin
                        n_shift     = r_shift << 1;
                        n_bits_left = bits_dec;
                        n_phase     = (bits_dec != '0) ? PH_BMARK : PH_SMARK;
                    end
                    PH_SMARK:  n_phase = PH_SSPACE;
                    default: begin
                        n_repeats = rep_dec;
                        if (rep_dec != '0) begin
                            // next repeat of the frame
                            n_shift     = r_frame;
                            n_bits_left = r_frame_len;
                            n_phase     = PH_LMARK;
                        end else begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_res.ir_out        = n_pin;
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.start_refused = refused;
        o_res.sequence_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_shift     <= '0;
            r_frame     <= '0;
            r_bits_left <= '0;
            r_frame_len <= '0;
            r_repeats   <= '0;
            r_pin       <= 1'b1;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_shift     <= n_shift;
            r_frame     <= n_frame;
            r_bits_left <= n_bits_left;
            r_frame_len <= n_frame_len;
            r_repeats   <= n_repeats;
            r_pin       <= n_pin;
        end
    end

endmodule

// ===== rtl/core/ir_pulse_distance_transmitter.sv =====
// Output: the result is registered into the output register, or into the skid entry while a result waits there.
// Throughput: one transaction per cycle; a two-entry output stage keeps input
// open while one result waits. Input stalls only when both entries are full.
// Reset (synchronous, active low): sequencer idle, pin high, output empty,
// registers back to their defaults. No clearing pass.
// Top level: APB register file, sequencer engine and output skid stage.
// Depends on irpdt_pkg and irpdt_engine.
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter
    import irpdt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_op,
    input  logic [FRAME_BITS_W-1:0] i_frame_bits,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_ir_out,
    output logic                    o_busy_res,
    output logic                    o_start_refused,
    output logic                    o_sequence_done
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 in_fire;
    logic                 out_fire;
    t_result              res;
    t_result              r_out, r_skid;
    logic                 r_out_valid, r_skid_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_mark     <= RST_LEADER_MARK;
            r_cfg.leader_space    <= RST_LEADER_SPACE;
            r_cfg.bit_mark        <= RST_BIT_MARK;
            r_cfg.one_space       <= RST_ONE_SPACE;
            r_cfg.zero_space      <= RST_ZERO_SPACE;
            r_cfg.stop_space      <= RST_STOP_SPACE;
            r_cfg.frame_bit_count <= RST_BIT_COUNT;
            r_cfg.frame_repeats   <= RST_REPEATS;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LEADER_MARK:  r_cfg.leader_mark     <= pwdata[SEG_LEN_W-1:0];
                REG_LEADER_SPACE: r_cfg.leader_space    <= pwdata[SEG_LEN_W-1:0];
                REG_BIT_MARK:     r_cfg.bit_mark        <= pwdata[SEG_LEN_W-1:0];
                REG_ONE_SPACE:    r_cfg.one_space       <= pwdata[SEG_LEN_W-1:0];
                REG_ZERO_SPACE:   r_cfg.zero_space      <= pwdata[SEG_LEN_W-1:0];
                REG_STOP_SPACE:   r_cfg.stop_space      <= pwdata[SEG_LEN_W-1:0];
                REG_BIT_COUNT:    r_cfg.frame_bit_count <= pwdata[BIT_COUNT_W-1:0];
                REG_REPEATS:      r_cfg.frame_repeats   <= pwdata[REPEATS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEADER_MARK:  prdata = APB_DATA_W'(r_cfg.leader_mark);
            REG_LEADER_SPACE: prdata = APB_DATA_W'(r_cfg.leader_space);
            REG_BIT_MARK:     prdata = APB_DATA_W'(r_cfg.bit_mark);
            REG_ONE_SPACE:    prdata = APB_DATA_W'(r_cfg.one_space);
            REG_ZERO_SPACE:   prdata = APB_DATA_W'(r_cfg.zero_space);
            REG_STOP_SPACE:   prdata = APB_DATA_W'(r_cfg.stop_space);
            REG_BIT_COUNT:    prdata = APB_DATA_W'(r_cfg.frame_bit_count);
            REG_REPEATS:      prdata = APB_DATA_W'(r_cfg.frame_repeats);
            default:          prdata = '0;
        endcase
    end

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;

    irpdt_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_op         (i_op),
        .i_frame_bits (i_frame_bits),
        .i_cfg        (r_cfg),
        .o_res        (res)
    );

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ir_out        = r_out.ir_out;
    assign o_busy_res      = r_out.busy_res;
    assign o_start_refused = r_out.start_refused;
    assign o_sequence_done = r_out.sequence_done;

endmodule

// ===== rtl/core/irpdt_checker.sv =====
// Port-level assertions for the IR pulse-distance transmitter, bound to the top.
// Depends on irpdt_pkg and ir_pulse_distance_transmitter.
`timescale 1ns / 1ps

module irpdt_checker
    import irpdt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_ir_out,
    input logic o_busy_res,
    input logic o_start_refused,
    input logic o_sequence_done
);

    // a refused start leaves the sequence running
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_start_refused |-> o_busy_res)
        else $error("start refused while not busy");

    // done comes with the sequence ending, never with a start
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sequence_done |-> !o_busy_res && !o_start_refused)
        else $error("sequence done while busy or refused");

    // pin rests high whenever no sequence runs
    a_idle_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_ir_out)
        else $error("pin low while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ir_out) && $stable(o_busy_res)
            && $stable(o_start_refused) && $stable(o_sequence_done))
        else $error("stalled result changed");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_ir_out        (o_ir_out),
    .o_busy_res      (o_busy_res),
    .o_start_refused (o_start_refused),
    .o_sequence_done (o_sequence_done)
);
